// ----- design/b64le_pkg.sv -----
`timescale 1ns / 1ps

package b64le_pkg;

  // Characters per output line before CR LF is inserted.
  localparam int LINE_CHARS = 76;

  // A job carries up to six characters: four from a group plus CR LF.
  localparam int JOB_CHARS   = 6;
  localparam int JOB_CNT_W   = $clog2(JOB_CHARS + 1);
  localparam int JOB_DEPTH   = 2;
  localparam int JOB_PTR_W   = $clog2(JOB_DEPTH);
  localparam int JOB_LEVEL_W = $clog2(JOB_DEPTH + 1);

  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  // Offsets that map a sextet onto its band of the standard alphabet.
  localparam logic [7:0] OFS_UPPER = 8'd65;
  localparam logic [7:0] OFS_LOWER = 8'd71;
  localparam logic [7:0] OFS_DIGIT = 8'd4;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    logic [JOB_CHARS-1:0][7:0] chars;
    logic [JOB_CNT_W-1:0]      n_chars;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return w + OFS_UPPER;
    end else if (v < 6'd52) begin
      return w + OFS_LOWER;
    end else if (v < 6'd62) begin
      return w - OFS_DIGIT;
    end else if (v == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

endpackage

// ----- design/base64_line_wrapped_encoder.sv -----
`timescale 1ns / 1ps

// Base64 encoder with MIME line wrapping: one raw byte per input transaction,
// one output character per result transaction, CR LF after every full line
// of LINE_CHARS characters and padding on the final partial group. The input
// takes a byte every cycle while the two-entry group queue has room; the
// output side sends one character per cycle while the consumer keeps popping
// and a group is queued, so throughput is set by that character port. A full
// group yields four characters (six when it closes a line), and a padded
// tail yields four characters for its one or two bytes.
module base64_line_wrapped_encoder import b64le_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  output out_item_t out_item,
  input  logic      out_pop
);

  logic in_accept;
  logic job_push;
  job_t job_new;
  logic head_valid;
  job_t head_job;
  logic job_pop;

  assign in_accept = in_push && !in_full;

  b64le_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .item     (in_item),
    .job_push (job_push),
    .job      (job_new)
  );

  b64le_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (job_new),
    .full       (in_full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64le_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (head_valid),
    .job       (head_job),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_item  (out_item),
    .out_pop   (out_pop)
  );

endmodule

// ----- design/b64le_front.sv -----
`timescale 1ns / 1ps

module b64le_front import b64le_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output logic     job_push,
  output job_t     job
);

  logic [15:0] pending_r, pending_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  line_r, line_nxt;

  logic [1:0]  phase;
  logic [7:0]  b, b0, b1;
  logic [8:0]  len9;
  logic        wrap;

  always_comb begin
    phase       = (phase_r == 2'd3) ? 2'd0 : phase_r;
    b           = item.byte_in;
    b0          = pending_r[15:8];
    b1          = pending_r[7:0];
    len9        = {1'b0, line_r} + 9'd4;
    wrap        = (len9 + 9'd4) > 9'(LINE_CHARS);

    pending_nxt = pending_r;
    phase_nxt   = phase_r;
    line_nxt    = line_r;
    job_push    = 1'b0;
    job.chars   = '0;
    job.n_chars = JOB_CNT_W'(4);

    case (phase)
      2'd0: begin
        job.chars[0] = b64_char(b[7:2]);
        job.chars[1] = b64_char({b[1:0], 4'b0000});
        job.chars[2] = CHAR_PAD;
        job.chars[3] = CHAR_PAD;
        if (accept) begin
          if (item.last_byte) begin
            job_push = 1'b1;
          end else begin
            pending_nxt = {b, 8'h00};
            phase_nxt   = 2'd1;
          end
        end
      end
      2'd1: begin
        job.chars[0] = b64_char(b0[7:2]);
        job.chars[1] = b64_char({b0[1:0], b[7:4]});
        job.chars[2] = b64_char({b[3:0], 2'b00});
        job.chars[3] = CHAR_PAD;
        if (accept) begin
          if (item.last_byte) begin
            job_push = 1'b1;
          end else begin
            pending_nxt = {b0, b};
            phase_nxt   = 2'd2;
          end
        end
      end
      default: begin
        job.chars[0] = b64_char(b0[7:2]);
        job.chars[1] = b64_char({b0[1:0], b1[7:4]});
        job.chars[2] = b64_char({b1[3:0], b[7:6]});
        job.chars[3] = b64_char(b[5:0]);
        if (wrap) begin
          job.chars[4] = CHAR_CR;
          job.chars[5] = CHAR_LF;
          job.n_chars  = JOB_CNT_W'(6);
        end
        if (accept) begin
          job_push    = 1'b1;
          pending_nxt = '0;
          phase_nxt   = 2'd0;
          line_nxt    = wrap ? 8'd0 : len9[7:0];
        end
      end
    endcase

    // The end of a message returns the encoder to the start of a fresh line.
    if (accept && item.last_byte) begin
      pending_nxt = '0;
      phase_nxt   = 2'd0;
      line_nxt    = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      phase_r   <= '0;
      line_r    <= '0;
    end else begin
      pending_r <= pending_nxt;
      phase_r   <= phase_nxt;
      line_r    <= line_nxt;
    end
  end

endmodule

// ----- design/b64le_fifo.sv -----
`timescale 1ns / 1ps

module b64le_fifo import b64le_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t                   mem_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [JOB_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [JOB_LEVEL_W-1:0] level_r, level_nxt;
  logic                   do_push, do_pop;

  assign full       = (level_r == JOB_LEVEL_W'(JOB_DEPTH));
  assign head_valid = (level_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

// ----- design/b64le_back.sv -----
`timescale 1ns / 1ps

module b64le_back import b64le_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_pop,
  output logic      out_empty,
  output out_item_t out_item,
  input  logic      out_pop
);

  logic [JOB_CNT_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;
  logic                 load, is_last;

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  // The output register is refilled in the same cycle that its character leaves, when a job is waiting.
  assign load    = job_valid && (!out_valid_r || out_pop);
  assign is_last = (idx_r == job.n_chars - 1'b1);
  assign job_pop = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_item_nxt.char_out  = job.chars[idx_r];
      out_item_nxt.last_char = is_last;
      out_valid_nxt          = 1'b1;
      idx_nxt                = is_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
